>>> design/pdfc_pkg.sv
// Package for the PWM duty/frequency capture block.
// Holds field widths, arithmetic constants and the sequencer state type.
// No dependencies; compile first.
package pdfc_pkg;

    localparam int TS_BITS_DEFAULT = 16;

    localparam int TIME_W = 16;
    localparam int CLK_W  = 24;
    localparam int DUTY_W = 14;
    localparam int FREQ_W = 31;

    localparam logic [CLK_W-1:0]  CLK_HZ_RESET    = 24'd125000;
    localparam logic [DUTY_W-1:0] DUTY_FULL_SCALE = 14'd10000;
    localparam logic [6:0]        CENTI           = 7'd100;

    // quotient bits per division
    localparam int DUTY_STEPS = DUTY_W;
    localparam int FREQ_STEPS = FREQ_W;
    localparam int CNT_W      = $clog2(FREQ_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_DUTY,
        ST_DIV_FREQ,
        ST_FINISH
    } pdfc_state_t;

endpackage

>>> design/pdfc_if.sv
// Handshake channels of the PWM duty/frequency capture block.
// Depends on pdfc_pkg for field widths.
interface pdfc_in_if;
    import pdfc_pkg::*;
    logic              valid;
    logic              ready;
    logic              edge_is_rising;
    logic [TIME_W-1:0] capture_time;

    modport source (output valid, edge_is_rising, capture_time, input ready);
    modport sink   (input valid, edge_is_rising, capture_time, output ready);
endinterface

interface pdfc_out_if;
    import pdfc_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] high_ticks;
    logic [TIME_W-1:0] period_ticks;
    logic [DUTY_W-1:0] duty_hundredths_pct;
    logic [FREQ_W-1:0] frequency_centihz;
    logic              measurement_valid;

    modport source (output valid, high_ticks, period_ticks, duty_hundredths_pct,
                    frequency_centihz, measurement_valid, input ready);
    modport sink   (input valid, high_ticks, period_ticks, duty_hundredths_pct,
                    frequency_centihz, measurement_valid, output ready);
endinterface

>>> design/pwm_duty_frequency_capture.sv
// Rising and ignored edge words leave the sequencer in ST_IDLE, so capture ready stays high.
// Falling edge word: busy until the result is registered. Invalid measurements skip both
// divisions; high time at or over the period clamps duty and skips its division. One shared
// restoring divider (one quotient bit per cycle) runs the 14-bit duty division, then the
// 31-bit frequency division. A finished result sits in an output register until taken.
// rst_n is asynchronous, active low: clock rate register back to 125000, edge state cleared.
module pwm_duty_frequency_capture
    import pdfc_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TS_BITS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    pdfc_in_if.sink          capture,
    pdfc_out_if.source       result,
    input  logic             cfg_we,
    input  logic [CLK_W-1:0] cfg_wdata
);

    localparam int TW  = TIMESTAMP_BITS;
    localparam int DPW = TW + DUTY_W;

    pdfc_state_t      state_reg, state_next;
    logic [CLK_W-1:0] clk_hz_reg;
    logic             wait_fall_reg, wait_fall_next;
    logic [TW-1:0]    pend_reg, pend_next;
    logic [TW-1:0]    last_reg, last_next;
    logic [1:0]       rises_reg, rises_next;
    logic             ov_reg, ov_next;

    logic [TW-1:0]     high_reg, high_next;
    logic [TW-1:0]     period_reg, period_next;
    logic              mvalid_reg, mvalid_next;
    logic [TW-1:0]     rem_reg, rem_next;
    logic [FREQ_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;

    logic [TIME_W-1:0] o_high_reg, o_high_next;
    logic [TIME_W-1:0] o_period_reg, o_period_next;
    logic [DUTY_W-1:0] o_duty_reg, o_duty_next;
    logic [FREQ_W-1:0] o_freq_reg, o_freq_next;
    logic              o_mvalid_reg, o_mvalid_next;

    logic              in_fire;
    logic [TW-1:0]     t_cur;
    logic [TW-1:0]     period_raw;
    logic [DPW-1:0]    duty_prod;
    logic [FREQ_W-1:0] freq_prod;
    logic [TW:0]       rem_sh;
    logic [TW:0]       rem_diff;
    logic              take;
    logic [TW-1:0]     rem_step;
    logic [FREQ_W-1:0] quo_step;

    assign capture.ready = (state_reg == ST_IDLE);
    assign in_fire       = capture.valid && capture.ready;
    assign t_cur         = TW'(capture.capture_time);
    assign period_raw    = pend_reg - last_reg;

    assign duty_prod = {{DUTY_W{1'b0}}, high_reg} * DPW'(DUTY_FULL_SCALE);
    assign freq_prod = {{(FREQ_W-CLK_W){1'b0}}, clk_hz_reg} * FREQ_W'(CENTI);

    // shared divider step: shift in the next numerator bit, subtract if it fits
    assign rem_sh   = {rem_reg, quo_reg[FREQ_W-1]};
    assign rem_diff = rem_sh - {1'b0, period_reg};
    assign take     = (rem_sh >= {1'b0, period_reg});
    assign rem_step = take ? rem_diff[TW-1:0] : rem_sh[TW-1:0];
    assign quo_step = {quo_reg[FREQ_W-2:0], take};

    assign result.valid               = ov_reg;
    assign result.high_ticks          = o_high_reg;
    assign result.period_ticks        = o_period_reg;
    assign result.duty_hundredths_pct = o_duty_reg;
    assign result.frequency_centihz   = o_freq_reg;
    assign result.measurement_valid   = o_mvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg    <= CLK_HZ_RESET;
            wait_fall_reg <= 1'b0;
            pend_reg      <= '0;
            last_reg      <= '0;
            rises_reg     <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                clk_hz_reg <= cfg_wdata;
            end
            wait_fall_reg <= wait_fall_next;
            pend_reg      <= pend_next;
            last_reg      <= last_next;
            rises_reg     <= rises_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        high_reg     <= high_next;
        period_reg   <= period_next;
        mvalid_reg   <= mvalid_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        duty_reg     <= duty_next;
        freq_reg     <= freq_next;
        o_high_reg   <= o_high_next;
        o_period_reg <= o_period_next;
        o_duty_reg   <= o_duty_next;
        o_freq_reg   <= o_freq_next;
        o_mvalid_reg <= o_mvalid_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        wait_fall_next = wait_fall_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        rises_next     = rises_reg;
        ov_next        = ov_reg;
        high_next      = high_reg;
        period_next    = period_reg;
        mvalid_next    = mvalid_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        duty_next      = duty_reg;
        freq_next      = freq_reg;
        o_high_next    = o_high_reg;
        o_period_next  = o_period_reg;
        o_duty_next    = o_duty_reg;
        o_freq_next    = o_freq_reg;
        o_mvalid_next  = o_mvalid_reg;

        if (result.valid && result.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!wait_fall_reg && capture.edge_is_rising)
                    begin
                        pend_next      = t_cur;
                        wait_fall_next = 1'b1;
                        if (!rises_reg[1])
                        begin
                            rises_next = rises_reg + 2'd1;
                        end
                    end
                    else if (wait_fall_reg && !capture.edge_is_rising)
                    begin
                        high_next      = t_cur - pend_reg;
                        period_next    = rises_reg[1] ? period_raw : '0;
                        mvalid_next    = rises_reg[1] && (period_raw != '0);
                        last_next      = pend_reg;
                        wait_fall_next = 1'b0;
                        state_next     = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                duty_next = '0;
                freq_next = '0;
                if (!mvalid_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (high_reg >= period_reg)
                begin
                    // quotient would reach full scale anyway: clamp and skip duty
                    duty_next  = DUTY_FULL_SCALE;
                    rem_next   = '0;
                    quo_next   = freq_prod;
                    cnt_next   = CNT_W'(FREQ_STEPS - 1);
                    state_next = ST_DIV_FREQ;
                end
                else
                begin
                    // high < period keeps the quotient below 2^14
                    rem_next   = duty_prod[DPW-1:DUTY_STEPS];
                    quo_next   = {duty_prod[DUTY_STEPS-1:0], {(FREQ_W-DUTY_STEPS){1'b0}}};
                    cnt_next   = CNT_W'(DUTY_STEPS - 1);
                    state_next = ST_DIV_DUTY;
                end
            end

            ST_DIV_DUTY:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    duty_next  = quo_step[DUTY_W-1:0];
                    rem_next   = '0;
                    quo_next   = freq_prod;
                    cnt_next   = CNT_W'(FREQ_STEPS - 1);
                    state_next = ST_DIV_FREQ;
                end
            end

            ST_DIV_FREQ:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    freq_next  = quo_step;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!ov_next)
                begin
                    ov_next       = 1'b1;
                    o_high_next   = TIME_W'(high_reg);
                    o_period_next = TIME_W'(period_reg);
                    o_duty_next   = duty_reg;
                    o_freq_next   = freq_reg;
                    o_mvalid_next = mvalid_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/pdfc_checker.sv
// Port-level assertions for the PWM duty/frequency capture block.
// Depends on pdfc_pkg; bound to pwm_duty_frequency_capture at the end of this file.
module pdfc_checker
    import pdfc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cap_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [TIME_W-1:0] res_high,
    input logic [TIME_W-1:0] res_period,
    input logic [DUTY_W-1:0] res_duty,
    input logic [FREQ_W-1:0] res_freq,
    input logic              res_mvalid
);

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_high) && $stable(res_period)
            && $stable(res_duty) && $stable(res_freq) && $stable(res_mvalid))
        else $error("result word changed while stalled");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_mvalid |-> (res_period != '0) && (res_duty <= DUTY_FULL_SCALE))
        else $error("valid measurement with zero period or duty over full scale");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_mvalid |-> (res_duty == '0) && (res_freq == '0))
        else $error("invalid measurement carries duty or frequency");

    // a new result only comes out of the busy sequencer
    a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cap_ready))
        else $error("result appeared while input side was idle");

endmodule

bind pwm_duty_frequency_capture pdfc_checker u_pdfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap_ready  (capture.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_high   (result.high_ticks),
    .res_period (result.period_ticks),
    .res_duty   (result.duty_hundredths_pct),
    .res_freq   (result.frequency_centihz),
    .res_mvalid (result.measurement_valid)
);

>>> tb/sv/tb_pwm_duty_frequency_capture.sv
`timescale 1ns / 100ps
// Testbench for pwm_duty_frequency_capture: a directed table, then random rise/fall pairs
// with noise, under several timer clock rates, each checked against a local predictor.
// Depends on pdfc_pkg and the pdfc_in_if / pdfc_out_if interfaces.
module tb_pwm_duty_frequency_capture;
    import pdfc_pkg::*;

    localparam int          RUN_LIMIT     = 500000;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          PAIRS_ITEMS   = 116;
    localparam int          RATE_PHASES   = 6;
    localparam int          DIRECTED_ROWS = 20;

    typedef struct packed {
        logic [TIME_W-1:0] high_ticks;
        logic [TIME_W-1:0] period_ticks;
        logic [DUTY_W-1:0] duty_hundredths_pct;
        logic [FREQ_W-1:0] frequency_centihz;
        logic              measurement_valid;
    } measurement_t;

    typedef struct packed {
        logic              rising;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        measurement_t      want;
    } capture_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CLK_W-1:0] cfg_wdata;

    pdfc_in_if  cap_if ();
    pdfc_out_if res_if ();

    pwm_duty_frequency_capture dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (cap_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic             awaiting_fall;
    logic [TIME_W-1:0] held_rise;
    logic [TIME_W-1:0] prev_rise;
    logic [1:0]       rise_count;
    logic [CLK_W-1:0] timer_rate;

    measurement_t     pending_measurements [$];
    int unsigned      mismatch_count = 0;
    int unsigned      measurements_checked = 0;
    int unsigned      edges_sent;
    int unsigned      cycle_count = 0;
    bit               no_idle;
    logic [TIME_W-1:0] gen_rise;

    // Expected values typed in are read straight off the rules; the rest come from the predictor.
    capture_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 16'h0050, 1'b0, '0},  // fall while awaiting a rise: drop
        '{1'b1, 16'h1000, 1'b0, '0},
        '{1'b1, 16'h1234, 1'b0, '0},  // rise while awaiting a fall: drop
        '{1'b0, 16'h1100, 1'b1, '{16'h0100, 16'h0000, 14'd0, 31'd0, 1'b0}},
        '{1'b1, 16'h2000, 1'b0, '0},
        '{1'b0, 16'h2080, 1'b0, '0},
        '{1'b1, 16'h2000, 1'b0, '0},  // same rise time again: zero period
        '{1'b0, 16'h2000, 1'b1, '{16'h0000, 16'h0000, 14'd0, 31'd0, 1'b0}},
        '{1'b1, 16'hFFF0, 1'b0, '0},
        '{1'b0, 16'h0010, 1'b0, '0},  // fall wraps past zero
        '{1'b1, 16'h0000, 1'b0, '0},
        '{1'b0, 16'hFFFF, 1'b1, '{16'hFFFF, 16'h0010, 14'd10000, 31'd781250, 1'b1}},
        '{1'b1, 16'h0001, 1'b0, '0},
        '{1'b0, 16'h0001, 1'b1, '{16'h0000, 16'h0001, 14'd0, 31'd12500000, 1'b1}},
        '{1'b1, 16'h0000, 1'b0, '0},
        '{1'b0, 16'hFFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 14'd10000, 31'd190, 1'b1}},
        '{1'b1, 16'hFFFF, 1'b0, '0},
        '{1'b1, 16'h5555, 1'b0, '0},
        '{1'b0, 16'hAAAA, 1'b0, '0},
        '{1'b0, 16'h0000, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic int unsigned draw_idle();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // Advance the edge state for one word; returns 1 when a measurement is due.
    function automatic bit measure_edge(input logic rising, input logic [TIME_W-1:0] stamp,
                                        output measurement_t m);
        logic [TIME_W-1:0] high_t;
        logic [TIME_W-1:0] span;
        logic [63:0]       duty;
        logic [63:0]       freq;
        bit                ok;
        m = '0;
        if (!awaiting_fall)
        begin
            if (rising)
            begin
                held_rise     = stamp;
                awaiting_fall = 1'b1;
                if (rise_count < 2)
                    rise_count = rise_count + 2'd1;
            end
            return 1'b0;
        end
        if (rising)
            return 1'b0;
        high_t = stamp - held_rise;
        span   = (rise_count >= 2) ? held_rise - prev_rise : '0;
        ok     = (rise_count >= 2) && (span != 0);
        duty   = '0;
        freq   = '0;
        if (ok)
        begin
            duty = 64'(high_t) * 64'(DUTY_FULL_SCALE) / 64'(span);
            if (duty > 64'(DUTY_FULL_SCALE))
                duty = 64'(DUTY_FULL_SCALE);
            freq = 64'(timer_rate) * 64'(CENTI) / 64'(span);
        end
        prev_rise     = held_rise;
        awaiting_fall = 1'b0;
        m.high_ticks          = high_t;
        m.period_ticks        = span;
        m.duty_hundredths_pct = duty[DUTY_W-1:0];
        m.frequency_centihz   = freq[FREQ_W-1:0];
        m.measurement_valid   = ok;
        return 1'b1;
    endfunction

    // Offer one capture word; return right after the edge that takes it.
    task automatic send_edge(input logic rising, input logic [TIME_W-1:0] stamp,
                             input logic typed = 1'b0, input measurement_t want = '0);
        int unsigned  gap;
        measurement_t m;
        gap = draw_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            cap_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cap_if.valid          = 1'b1;
        cap_if.edge_is_rising = rising;
        cap_if.capture_time   = stamp;
        do @(posedge clk); while (!cap_if.ready);
        edges_sent++;
        if (measure_edge(rising, stamp, m))
            pending_measurements.push_back(typed ? want : m);
    endtask

    // Drop valid and hold until every measurement has come back.
    task automatic drain_results();
        @(negedge clk);
        cap_if.valid = 1'b0;
        while (pending_measurements.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_timer_rate(input logic [CLK_W-1:0] rate);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = rate;
        @(negedge clk);
        cfg_we     = 1'b0;
        timer_rate = rate;
    endtask

    // Well-formed rise/fall pairs with random spans, plus stray edges the block must drop.
    task automatic run_pairs(input int unsigned count);
        int unsigned       sent;
        int unsigned       pick;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] high_t;
        logic [TIME_W-1:0] rise_t;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 39) == 0)
                drain_results();
            if ($urandom_range(0, 31) == 0)
                no_idle = !no_idle;
            pick = $urandom_range(0, 9);
            case (pick)
                0:       span = '0;
                1, 2:    span = TIME_W'($urandom_range(1, 16));
                3:       span = 16'hFFFF - TIME_W'($urandom_range(0, 3));
                default: span = TIME_W'($urandom);
            endcase
            rise_t = gen_rise + span;
            if ($urandom_range(0, 9) == 0)
                send_edge(1'b0, TIME_W'($urandom));
            send_edge(1'b1, rise_t);
            gen_rise = rise_t;
            pick = $urandom_range(0, 9);
            case (pick)
                0:       high_t = '0;
                1:       high_t = span;
                2:       high_t = span + TIME_W'($urandom_range(1, 100));
                3:       high_t = 16'hFFFF;
                default: high_t = TIME_W'($urandom_range(0, span));
            endcase
            if ($urandom_range(0, 9) == 0)
                send_edge(1'b1, TIME_W'($urandom));
            send_edge(1'b0, rise_t + high_t);
            sent += 2;
        end
    endtask

    initial
    begin : result_sink
        int unsigned  stall;
        measurement_t want;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_idle();
            @(negedge clk);
            if (stall == 0)
                res_if.ready = 1'b1;
            else
            begin
                res_if.ready = 1'b0;
                do @(posedge clk); while (!res_if.valid);
                repeat (stall) @(negedge clk);
                res_if.ready = 1'b1;
            end
            do @(posedge clk); while (!res_if.valid);
            measurements_checked++;
            if (pending_measurements.size() == 0)
                flag_mismatch("result word with no measurement pending");
            else
            begin
                want = pending_measurements.pop_front();
                if (res_if.high_ticks !== want.high_ticks)
                    flag_mismatch($sformatf("high_ticks %0h, expected %0h",
                                            res_if.high_ticks, want.high_ticks));
                if (res_if.period_ticks !== want.period_ticks)
                    flag_mismatch($sformatf("period_ticks %0h, expected %0h",
                                            res_if.period_ticks, want.period_ticks));
                if (res_if.duty_hundredths_pct !== want.duty_hundredths_pct)
                    flag_mismatch($sformatf("duty_hundredths_pct %0d, expected %0d",
                                            res_if.duty_hundredths_pct,
                                            want.duty_hundredths_pct));
                if (res_if.frequency_centihz !== want.frequency_centihz)
                    flag_mismatch($sformatf("frequency_centihz %0d, expected %0d",
                                            res_if.frequency_centihz, want.frequency_centihz));
                if (res_if.measurement_valid !== want.measurement_valid)
                    flag_mismatch($sformatf("measurement_valid %0b, expected %0b",
                                            res_if.measurement_valid, want.measurement_valid));
            end
        end
    end

    initial
    begin : stimulus
        logic [CLK_W-1:0] rates [RATE_PHASES];
        edges_sent            = 0;
        no_idle               = 1'b0;
        gen_rise              = TIME_W'($urandom);
        awaiting_fall         = 1'b0;
        held_rise             = '0;
        prev_rise             = '0;
        rise_count            = '0;
        timer_rate            = CLK_HZ_RESET;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        cap_if.valid          = 1'b0;
        cap_if.edge_is_rising = 1'b0;
        cap_if.capture_time   = '0;
        rates[0] = 24'd1;
        rates[1] = 24'hFFFFFF;
        rates[2] = 24'd16000000;
        rates[3] = 24'd0;
        rates[4] = CLK_W'($urandom_range(1, 16000000));
        rates[5] = CLK_HZ_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_edge(directed_rows[i].rising, directed_rows[i].stamp,
                      directed_rows[i].typed, directed_rows[i].want);

        // one stretch with the reset rate, then each rate in turn
        run_pairs(PAIRS_ITEMS / 2);
        for (int p = 0; p < RATE_PHASES; p++)
        begin
            set_timer_rate(rates[p]);
            no_idle = (p % 3 == 2);
            run_pairs(PAIRS_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d capture words, checked %0d measurements", edges_sent,
                 measurements_checked);
        $display("Timer rates covered: reset value, 1, 16777215, 16000000, 0 and %0d",
                 rates[4]);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> pwm_duty_frequency_capture.f
design/pdfc_pkg.sv
design/pdfc_if.sv
design/pwm_duty_frequency_capture.sv
design/pdfc_checker.sv
tb/sv/tb_pwm_duty_frequency_capture.sv
